FILE: design/tlst_pkg.sv
// Package of shared constants and codes for the timetable line store.
package tlst_pkg;

    localparam int MAX_STOPS_DEF = 32;
    localparam int MAX_TRIPS_DEF = 64;

    localparam logic [30:0] TIME_NONE = 31'h7FFF_FFFF;
    localparam logic [31:0] COST_NONE = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_REJECTED  = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NONE      = 3'd5,
        ST_BAD_POS   = 3'd6
    } status_t;

    typedef enum logic {
        ACT_STOP  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

endpackage

FILE: design/tlst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/timetable_line_store.sv
// Top level of the timetable line store: stream ports, sequencer and memories.
//
// The block keeps one timetable line. A stop item (s_tuser = 0) is staged; the
// item with s_tlast closes the trip, which is checked against the line and the
// earliest stored trip and then inserted by departure order. A close runs the
// stop check, the order scan over the stored trips, the shift of rank entries
// and the copy of the stops into the trip memory. A query (s_tuser = 1) scans
// the stored trips in departure order, or ends at once when the store is empty
// or a position lies beyond the line. The trip memory and the rank table each
// have a single read port and are read one entry per step. One result is given
// per closed trip or query; the output register lets the next item enter while
// a result waits. No clearing pass is needed after reset.
module timetable_line_store
    import tlst_pkg::*;
#(
    parameter int MAX_STOPS = MAX_STOPS_DEF,
    parameter int MAX_TRIPS = MAX_TRIPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // stop_id[15:0], arrival_time[46:16], departure_time[77:47],
    // start_position[82:78], dest_position[87:83], query_time[118:88], zero[119]
    input  logic [119:0] s_tdata,
    // action[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cost[31:0], next_departure[62:32], zero[63]
    output logic [63:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    localparam int SW = $clog2(MAX_STOPS);
    localparam int LW = $clog2(MAX_STOPS + 1);
    localparam int TW = (MAX_TRIPS > 1) ? $clog2(MAX_TRIPS) : 1;
    localparam int CW = $clog2(MAX_TRIPS + 1);
    localparam int PW = (LW > 5) ? LW : 5;

    typedef enum logic [4:0] {
        S_IDLE, S_CLOSE, S_CK_R0, S_CK_RD, S_CK_CMP, S_FIRST, S_FIRST_W,
        S_SC_RANK, S_SC_SLOT, S_SC_EVAL, S_SC_END, S_SH_RD, S_SH_WR,
        S_CP_RD, S_CP_WR, S_Q_START, S_Q_RANK, S_Q_SLOT, S_Q_EVAL, S_Q_COST,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            ovf_reg, ovf_next;
    logic [LW-1:0]   line_len_reg, line_len_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   t_reg, t_next;
    logic [TW-1:0]   slot_reg, slot_next;
    logic [30:0]     first_reg, first_next;
    logic [30:0]     prev_sdep_reg, prev_sdep_next;
    logic [30:0]     prev_tdep_reg, prev_tdep_next;
    logic [4:0]      sp_reg, sp_next;
    logic [4:0]      dp_reg, dp_next;
    logic [30:0]     qt_reg, qt_next;
    logic            query_reg, query_next;
    status_t         res_status_reg, res_status_next;
    logic [31:0]     res_cost_reg, res_cost_next;
    logic [30:0]     res_dep_reg, res_dep_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [31:0]     out_cost_reg, out_cost_next;
    logic [30:0]     out_dep_reg, out_dep_next;

    // Memory ports
    logic            stg_we;
    logic [SW-1:0]   stg_waddr, stg_raddr;
    logic [77:0]     stg_wdata, stg_rdata;
    logic            line_we;
    logic [SW-1:0]   line_waddr, line_raddr;
    logic [15:0]     line_wdata, line_rdata;
    logic            trip_we;
    logic [TW+SW-1:0] trip_waddr, trip_raddr;
    logic [61:0]     trip_wdata, trip_rdata;
    logic            rank_we;
    logic [TW-1:0]   rank_waddr, rank_raddr;
    logic [TW-1:0]   rank_wdata, rank_rdata;

    logic            s_acc;
    logic [LW-1:0]   idx_inc;
    logic [32:0]     travel_s, travel_t;
    logic [PW-1:0]   sp_w, dp_w, line_len_w;

    tlst_ram #(.WIDTH(78), .DEPTH(2 ** SW)) u_stage (
        .aclk(aclk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
        .raddr(stg_raddr), .rdata(stg_rdata)
    );
    tlst_ram #(.WIDTH(16), .DEPTH(2 ** SW)) u_line (
        .aclk(aclk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
        .raddr(line_raddr), .rdata(line_rdata)
    );
    tlst_ram #(.WIDTH(62), .DEPTH(2 ** (TW + SW))) u_trip (
        .aclk(aclk), .we(trip_we), .waddr(trip_waddr), .wdata(trip_wdata),
        .raddr(trip_raddr), .rdata(trip_rdata)
    );
    tlst_ram #(.WIDTH(TW), .DEPTH(2 ** TW)) u_rank (
        .aclk(aclk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
        .raddr(rank_raddr), .rdata(rank_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_dep_reg, out_cost_reg};

    assign idx_inc    = idx_reg + 1'b1;
    assign travel_s   = {2'b0, stg_rdata[61:31]} - {2'b0, prev_sdep_reg};
    assign travel_t   = {2'b0, trip_rdata[61:31]} - {2'b0, prev_tdep_reg};
    assign sp_w       = PW'(sp_reg);
    assign dp_w       = PW'(dp_reg);
    assign line_len_w = PW'(line_len_reg);

    // Sequencer: next state, memory accesses and result
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        line_len_next   = line_len_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        t_next          = t_reg;
        slot_next       = slot_reg;
        first_next      = first_reg;
        prev_sdep_next  = prev_sdep_reg;
        prev_tdep_next  = prev_tdep_reg;
        sp_next         = sp_reg;
        dp_next         = dp_reg;
        qt_next         = qt_reg;
        query_next      = query_reg;
        res_status_next = res_status_reg;
        res_cost_next   = res_cost_reg;
        res_dep_next    = res_dep_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_cost_next   = out_cost_reg;
        out_dep_next    = out_dep_reg;

        stg_we     = 1'b0;
        stg_waddr  = len_reg[SW-1:0];
        stg_wdata  = {s_tdata[15:0], s_tdata[46:16], s_tdata[77:47]};
        stg_raddr  = idx_reg[SW-1:0];
        line_we    = 1'b0;
        line_waddr = idx_reg[SW-1:0];
        line_wdata = stg_rdata[77:62];
        line_raddr = idx_reg[SW-1:0];
        trip_we    = 1'b0;
        trip_waddr = {count_reg[TW-1:0], idx_reg[SW-1:0]};
        trip_wdata = stg_rdata[61:0];
        trip_raddr = {slot_reg, idx_reg[SW-1:0]};
        rank_we    = 1'b0;
        rank_waddr = t_reg[TW-1:0];
        rank_wdata = rank_rdata;
        rank_raddr = pos_reg[TW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] == ACT_QUERY) begin
                        sp_next    = s_tdata[82:78];
                        dp_next    = s_tdata[87:83];
                        qt_next    = s_tdata[118:88];
                        query_next = 1'b1;
                        state_next = S_Q_START;
                    end else begin
                        query_next = 1'b0;
                        // stage the stop, or mark the trip as overlong
                        if (len_reg < LW'(MAX_STOPS)) begin
                            stg_we   = 1'b1;
                            len_next = len_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (s_tlast) begin
                            state_next = S_CLOSE;
                        end
                    end
                end
            end
            S_CLOSE: begin
                res_cost_next = '0;
                res_dep_next  = '0;
                if (ovf_reg) begin
                    res_status_next = ST_REJECTED;
                    state_next      = S_DONE;
                end else if (line_len_reg != '0) begin
                    if (len_reg != line_len_reg) begin
                        res_status_next = ST_MISMATCH;
                        state_next      = S_DONE;
                    end else begin
                        rank_raddr = '0;
                        state_next = S_CK_R0;
                    end
                end else begin
                    state_next = S_FIRST;
                end
            end
            S_CK_R0: begin
                slot_next  = rank_rdata;
                idx_next   = '0;
                state_next = S_CK_RD;
            end
            S_CK_RD: begin
                state_next = S_CK_CMP;
            end
            S_CK_CMP: begin
                // compare stop id against the line and travel time against the earliest trip
                prev_sdep_next = stg_rdata[30:0];
                prev_tdep_next = trip_rdata[30:0];
                if (stg_rdata[77:62] != line_rdata ||
                    (idx_reg != '0 && travel_s != travel_t)) begin
                    res_status_next = ST_MISMATCH;
                    state_next      = S_DONE;
                end else if (idx_inc == len_reg) begin
                    state_next = S_FIRST;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_CK_RD;
                end
            end
            S_FIRST: begin
                stg_raddr  = '0;
                state_next = S_FIRST_W;
            end
            S_FIRST_W: begin
                first_next = stg_rdata[30:0];
                pos_next   = '0;
                state_next = S_SC_RANK;
            end
            S_SC_RANK: begin
                if (pos_reg == count_reg) begin
                    state_next = S_SC_END;
                end else begin
                    state_next = S_SC_SLOT;
                end
            end
            S_SC_SLOT: begin
                trip_raddr = {rank_rdata, {SW{1'b0}}};
                state_next = S_SC_EVAL;
            end
            S_SC_EVAL: begin
                // advance past earlier first departures
                if (trip_rdata[30:0] < first_reg) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_SC_RANK;
                end else if (trip_rdata[30:0] == first_reg) begin
                    res_status_next = ST_DUPLICATE;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_SC_END;
                end
            end
            S_SC_END: begin
                if (count_reg == CW'(MAX_TRIPS)) begin
                    res_status_next = ST_REJECTED;
                    state_next      = S_DONE;
                end else begin
                    t_next     = count_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (t_reg == pos_reg) begin
                    // new trip goes to the free slot at the end
                    rank_we    = 1'b1;
                    rank_wdata = count_reg[TW-1:0];
                    idx_next   = '0;
                    state_next = S_CP_RD;
                end else begin
                    rank_raddr = TW'(t_reg - 1'b1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                rank_we    = 1'b1;
                t_next     = t_reg - 1'b1;
                state_next = S_SH_RD;
            end
            S_CP_RD: begin
                state_next = S_CP_WR;
            end
            S_CP_WR: begin
                // copy the staged stop into the trip memory
                trip_we = 1'b1;
                line_we = (line_len_reg == '0);
                if (idx_inc == len_reg) begin
                    if (line_len_reg == '0) begin
                        line_len_next = len_reg;
                    end
                    count_next      = count_reg + 1'b1;
                    res_status_next = ST_STORED;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_CP_RD;
                end
            end
            S_Q_START: begin
                res_cost_next = COST_NONE;
                res_dep_next  = TIME_NONE;
                if (count_reg == '0) begin
                    res_status_next = ST_NONE;
                    state_next      = S_DONE;
                end else if (sp_w >= line_len_w || dp_w >= line_len_w) begin
                    res_status_next = ST_BAD_POS;
                    state_next      = S_DONE;
                end else begin
                    t_next     = '0;
                    state_next = S_Q_RANK;
                end
            end
            S_Q_RANK: begin
                rank_raddr = t_reg[TW-1:0];
                if (t_reg == count_reg) begin
                    res_status_next = ST_NONE;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_Q_SLOT;
                end
            end
            S_Q_SLOT: begin
                slot_next  = rank_rdata;
                trip_raddr = {rank_rdata, SW'(sp_reg)};
                state_next = S_Q_EVAL;
            end
            S_Q_EVAL: begin
                trip_raddr = {slot_reg, SW'(dp_reg)};
                if (trip_rdata[30:0] >= qt_reg) begin
                    res_dep_next = trip_rdata[30:0];
                    state_next   = S_Q_COST;
                end else begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_Q_RANK;
                end
            end
            S_Q_COST: begin
                res_cost_next   = {1'b0, trip_rdata[61:31]} - {1'b0, qt_reg};
                res_status_next = ST_FOUND;
                state_next      = S_DONE;
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_cost_next   = res_cost_reg;
                    out_dep_next    = res_dep_reg;
                    if (!query_reg) begin
                        len_next = '0;
                        ovf_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            line_len_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            line_len_reg  <= line_len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        t_reg          <= t_next;
        slot_reg       <= slot_next;
        first_reg      <= first_next;
        prev_sdep_reg  <= prev_sdep_next;
        prev_tdep_reg  <= prev_tdep_next;
        sp_reg         <= sp_next;
        dp_reg         <= dp_next;
        qt_reg         <= qt_next;
        query_reg      <= query_next;
        res_status_reg <= res_status_next;
        res_cost_reg   <= res_cost_next;
        res_dep_reg    <= res_dep_next;
        out_status_reg <= out_status_next;
        out_cost_reg   <= out_cost_next;
        out_dep_reg    <= out_dep_next;
    end

endmodule
